[sv/tlblru_pkg.sv]
// shared types and constants for the fully associative translation buffer
// no dependencies; imported by tlblru_cell and tlb_with_lru_replacement
package tlblru_pkg;

	// buffer geometry and field widths
	localparam int ENTRIES = 16;
	localparam int RANK_W  = $clog2(ENTRIES);
	localparam int PAGE_W  = 8;
	localparam int FRAME_W = 8;
	localparam int CNT_W   = 32;

	// rank held by the oldest entry of a full buffer
	localparam logic [RANK_W-1:0] RANK_OLDEST = RANK_W'(ENTRIES - 1);

	// command opcodes
	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_ADD    = 1'b1
	} op_t;

	// control sequencer states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// input beat
	typedef struct packed {
		op_t                op;
		logic [PAGE_W-1:0]  page_number;
		logic [FRAME_W-1:0] frame_number;
	} cmd_t;

	// result beat
	typedef struct packed {
		logic               hit;
		logic [FRAME_W-1:0] frame_out;
		logic [CNT_W-1:0]   hit_count;
	} result_t;

	// data passed from each cell to its right-hand neighbor
	typedef struct packed {
		logic               seen_free;
		logic               any_match;
		logic [FRAME_W-1:0] frame;
		logic [RANK_W-1:0]  rank;
	} chain_t;

	// control broadcast from the top level to every cell
	typedef struct packed {
		logic               upd_en;
		logic               found;
		logic               full;
		logic [RANK_W-1:0]  found_rank;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
	} cell_ctl_t;

endpackage

[sv/tlblru_cell.sv]
// one entry of the translation buffer: page/frame storage, match and recency rank
// depends on tlblru_pkg; chained left to right inside tlb_with_lru_replacement
module tlblru_cell import tlblru_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  chain_t    chain_in,
	output chain_t    chain_out
);

	logic               valid_q;
	logic [PAGE_W-1:0]  page_q;
	logic [FRAME_W-1:0] frame_q;
	logic [RANK_W-1:0]  rank_q;

	logic match;
	logic first_free;
	logic victim;
	logic take;

	// local compare and slot selection
	assign match      = valid_q && (page_q == ctl.page);
	assign first_free = !valid_q && !chain_in.seen_free;
	assign victim     = valid_q && (rank_q == RANK_OLDEST);
	assign take       = ctl.full ? victim : first_free;

	// hand match data and free-slot status to the neighbor
	always_comb begin
		chain_out.seen_free = chain_in.seen_free || !valid_q;
		chain_out.any_match = chain_in.any_match || match;
		chain_out.frame     = chain_in.frame | (match ? frame_q : '0);
		chain_out.rank      = chain_in.rank | (match ? rank_q : '0);
	end

	// valid bit and recency rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (ctl.upd_en) begin
			if (ctl.found) begin
				if (match) begin
					rank_q <= '0;
				end else if (valid_q && (rank_q < ctl.found_rank)) begin
					rank_q <= rank_q + 1'b1;
				end
			end else if (take) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (valid_q) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	// mapping payload
	always_ff @(posedge clk) begin
		if (ctl.upd_en) begin
			if (ctl.found) begin
				if (match) begin
					frame_q <= ctl.frame;
				end
			end else if (take) begin
				page_q  <= ctl.page;
				frame_q <= ctl.frame;
			end
		end
	end

endmodule

[sv/tlb_with_lru_replacement.sv]
// fully associative translation buffer, least-recently-added replacement
// depends on tlblru_pkg and a row of tlblru_cell entries
// an accepted command is registered on the move to the execute state, and the result and done are registered from there
// no new command is taken while busy; the match/update pass over the cell row runs in the execute state
// reset: all entries invalid, ranks and hit counter cleared; the receiver cannot stall
// done pulses for one cycle per command, busy is high for the cycle after each accept
module tlb_with_lru_replacement import tlblru_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    done,
	output result_t result
);

	state_t state_q;
	state_t state_nxt;
	logic   exec_en;
	logic   accept;

	cmd_t             cmd_q;
	logic [CNT_W-1:0] hits_q;
	logic [CNT_W-1:0] hits_nxt;
	logic             done_q;
	result_t          result_q;

	chain_t    chain_w [ENTRIES+1];
	chain_t    chain_end;
	cell_ctl_t ctl;
	logic      is_lookup;

	assign accept = start && !busy;

	// next state
	always_comb begin
		case (state_q)
			ST_IDLE: state_nxt = accept ? ST_EXEC : ST_IDLE;
			ST_EXEC: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		case (state_q)
			ST_IDLE: begin
				busy    = 1'b0;
				exec_en = 1'b0;
			end
			ST_EXEC: begin
				busy    = 1'b1;
				exec_en = 1'b1;
			end
			default: begin
				busy    = 1'b0;
				exec_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// command register
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
	end

	// row of entry cells
	assign chain_w[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		tlblru_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.chain_in  (chain_w[i]),
			.chain_out (chain_w[i+1])
		);
	end

	assign chain_end = chain_w[ENTRIES];
	assign is_lookup = (cmd_q.op == OP_LOOKUP);

	// broadcast to the cells
	always_comb begin
		ctl.upd_en     = exec_en && (cmd_q.op == OP_ADD);
		ctl.found      = chain_end.any_match;
		ctl.full       = !chain_end.seen_free;
		ctl.found_rank = chain_end.rank;
		ctl.page       = cmd_q.page_number;
		ctl.frame      = cmd_q.frame_number;
	end

	// saturating lookup hit counter
	always_comb begin
		hits_nxt = hits_q;
		if (is_lookup && chain_end.any_match && (hits_q != '1)) begin
			hits_nxt = hits_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= exec_en;
			if (exec_en) begin
				hits_q <= hits_nxt;
			end
		end
	end

	// result beat register
	always_ff @(posedge clk) begin
		if (exec_en) begin
			result_q.hit       <= chain_end.any_match;
			result_q.frame_out <= (is_lookup && chain_end.any_match) ? chain_end.frame : '0;
			result_q.hit_count <= hits_nxt;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[tb/tb_tlb_with_lru_replacement.sv]
// self-checking testbench for the fully associative translation buffer with lru replacement
// depends on tlblru_pkg and tlb_with_lru_replacement; checks each result beat against
// a behavioral model of entry match, recency ranking, eviction and the saturating hit counter
module tb_tlb_with_lru_replacement;
	import tlblru_pkg::*;

	localparam int RANDOM_CMDS  = 1100;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	cmd_t    cmd = '0;
	logic    busy;
	logic    done;
	result_t result;

	tlb_with_lru_replacement dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	// command waiting to be driven, optionally after the buffer has gone quiet
	typedef struct {
		cmd_t c;
		bit   settle;
	} queued_cmd_t;

	queued_cmd_t cmd_backlog[$];
	result_t     expected_translations[$];

	// model copy of the buffer contents
	logic              tlb_valid [ENTRIES];
	logic [PAGE_W-1:0]  tlb_page  [ENTRIES];
	logic [FRAME_W-1:0] tlb_frame [ENTRIES];
	logic [RANK_W-1:0]  tlb_rank  [ENTRIES];
	logic [CNT_W-1:0]   hit_total = '0;

	int errors = 0;
	int accepted_cnt = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	int n_lookups = 0;
	int n_lookup_hits = 0;
	int n_adds = 0;
	int n_updates = 0;
	int n_evictions = 0;
	result_t want;

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			tlb_valid[i] = 1'b0;
			tlb_page[i]  = '0;
			tlb_frame[i] = '0;
			tlb_rank[i]  = '0;
		end
	end

	// translate one command and advance the model state
	function automatic result_t translate_cmd(cmd_t c);
		int i;
		int slot;
		int victim;
		result_t r;
		slot = -1;
		for (i = 0; i < ENTRIES; i++)
			if (slot < 0 && tlb_valid[i] && tlb_page[i] == c.page_number)
				slot = i;
		r = '0;
		r.hit = (slot >= 0);
		if (c.op == OP_LOOKUP) begin
			n_lookups++;
			if (slot >= 0) begin
				r.frame_out = tlb_frame[slot];
				n_lookup_hits++;
				if (hit_total != '1)
					hit_total = hit_total + 1'b1;
			end
		end else begin
			n_adds++;
			if (slot >= 0) begin
				// update in place: only younger entries age
				for (i = 0; i < ENTRIES; i++)
					if (tlb_valid[i] && tlb_rank[i] < tlb_rank[slot])
						tlb_rank[i] = tlb_rank[i] + 1'b1;
				tlb_frame[slot] = c.frame_number;
				tlb_rank[slot]  = '0;
				n_updates++;
			end else begin
				// lowest free slot, else the oldest entry
				victim = -1;
				for (i = 0; i < ENTRIES; i++)
					if (victim < 0 && !tlb_valid[i])
						victim = i;
				if (victim < 0) begin
					victim = 0;
					for (i = 1; i < ENTRIES; i++)
						if (tlb_rank[i] > tlb_rank[victim])
							victim = i;
					tlb_valid[victim] = 1'b0;
					n_evictions++;
				end
				for (i = 0; i < ENTRIES; i++)
					if (tlb_valid[i])
						tlb_rank[i] = tlb_rank[i] + 1'b1;
				tlb_valid[victim] = 1'b1;
				tlb_page[victim]  = c.page_number;
				tlb_frame[victim] = c.frame_number;
				tlb_rank[victim]  = '0;
			end
		end
		r.hit_count = hit_total;
		return r;
	endfunction

	task automatic flag_error(string msg);
		errors++;
		if (errors <= 10)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic queue_cmd(op_t op, int page, int frame, bit settle);
		queued_cmd_t q;
		q.c.op           = op;
		q.c.page_number  = PAGE_W'(page);
		q.c.frame_number = FRAME_W'(frame);
		q.settle         = settle;
		cmd_backlog.push_back(q);
	endtask

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// command driver: holds a beat until taken, idles at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd   <= '0;
		end else begin
			if (start && !busy) begin
				expected_translations.push_back(translate_cmd(cmd));
				accepted_cnt++;
			end
			if (!(start && busy)) begin
				if (cmd_backlog.size() != 0
				    && !(cmd_backlog[0].settle && expected_translations.size() != 0)
				    && !(($urandom_range(0, 99) < 31)
				         && !(accepted_cnt >= 500 && accepted_cnt < 700))) begin
					start <= 1'b1;
					cmd   <= cmd_backlog[0].c;
					cmd_backlog.delete(0);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor: one beat per done strobe, compared field by field
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (expected_translations.size() == 0) begin
				flag_error($sformatf("unexpected result hit=%0d frame=%0h count=%0d",
					result.hit, result.frame_out, result.hit_count));
			end else begin
				want = expected_translations.pop_front();
				if (result.hit !== want.hit || result.frame_out !== want.frame_out
				    || result.hit_count !== want.hit_count)
					flag_error($sformatf(
						"beat %0d exp hit=%0d frame=%0h count=%0d got hit=%0d frame=%0h count=%0d",
						results_seen, want.hit, want.frame_out, want.hit_count,
						result.hit, result.frame_out, result.hit_count));
			end
		end
	end

	// watchdog on cycles with no beat in either direction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d quiet cycles", idle_cycles);
				$display("[tlb_with_lru_replacement] ERROR");
				$finish;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		// empty buffer misses at both page extremes, then both pages are added and looked up
		queue_cmd(OP_LOOKUP, 0, 8'hFF, 1'b0);
		queue_cmd(OP_LOOKUP, 255, 0, 1'b0);
		queue_cmd(OP_ADD, 0, 8'hFF, 1'b0);
		queue_cmd(OP_ADD, 255, 0, 1'b0);
		queue_cmd(OP_LOOKUP, 0, 0, 1'b0);
		queue_cmd(OP_LOOKUP, 255, 8'hFF, 1'b0);
		// add of a present page replaces its frame and makes it youngest
		queue_cmd(OP_ADD, 0, 8'hAA, 1'b0);
		queue_cmd(OP_LOOKUP, 0, 0, 1'b0);
		// fill the remaining slots
		for (int p = 1; p <= ENTRIES - 2; p++)
			queue_cmd(OP_ADD, p, 8'h10 + p, 1'b0);
		// full buffer: new page evicts the oldest, then a miss leaves state alone
		queue_cmd(OP_ADD, 8'h80, 8'h55, 1'b0);
		queue_cmd(OP_LOOKUP, 255, 0, 1'b0);
		queue_cmd(OP_LOOKUP, 0, 0, 1'b0);
		queue_cmd(OP_ADD, 7, 8'h77, 1'b0);
		queue_cmd(OP_ADD, 8'h81, 8'h01, 1'b0);
		queue_cmd(OP_LOOKUP, 7, 0, 1'b0);

		// random traffic, mostly on a small page pool so hits and evictions are common
		for (int n = 0; n < RANDOM_CMDS; n++)
			queue_cmd(($urandom_range(0, 99) < 45) ? OP_ADD : OP_LOOKUP,
				($urandom_range(0, 99) < 75) ? $urandom_range(0, 23) : $urandom_range(0, 255),
				$urandom_range(0, 255),
				(n == 0 || n == 300 || n == 650 || n == 900));

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (cmd_backlog.size() != 0 || start || expected_translations.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_translations.size() != 0)
			flag_error($sformatf("%0d results never arrived", expected_translations.size()));

		$display("ran %0d commands: %0d lookups with %0d hits, %0d adds", accepted_cnt,
			n_lookups, n_lookup_hits, n_adds);
		$display("adds covered %0d in-place updates and %0d evictions; %0d mismatches",
			n_updates, n_evictions, errors);
		if (errors == 0)
			$display("[tlb_with_lru_replacement] OK");
		else
			$display("[tlb_with_lru_replacement] ERROR");
		$finish;
	end

endmodule
